FILE: hw/rtl/tmq_pkg.sv
// ----------------------------------------------------------------------------
// tmq_pkg
// Command codes, status codes and state encoding for the timer queue core.
// ----------------------------------------------------------------------------
package tmq_pkg;

    localparam int NUM_TIMERS = 32;

    localparam logic [2:0] K_CREATE = 3'd0;
    localparam logic [2:0] K_START  = 3'd1;
    localparam logic [2:0] K_STOP   = 3'd2;
    localparam logic [2:0] K_SETEV  = 3'd3;
    localparam logic [2:0] K_GETEV  = 3'd4;
    localparam logic [2:0] K_TICK   = 3'd5;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NOFREE   = 3'd1;
    localparam logic [2:0] ST_UNUSED   = 3'd2;
    localparam logic [2:0] ST_NOEVENT  = 3'd3;
    localparam logic [2:0] ST_RUNNING  = 3'd4;
    localparam logic [2:0] ST_STOPPED  = 3'd5;
    localparam logic [2:0] ST_EVSET    = 3'd6;

    localparam logic CFG_MIN_PERIOD   = 1'b0;
    localparam logic CFG_EARLY_WINDOW = 1'b1;

    localparam logic [23:0] RST_MIN_PERIOD   = 24'd1000;
    localparam logic [23:0] RST_EARLY_WINDOW = 24'd1000;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_CMD  = 6'b000010,
        S_TBND = 6'b000100,
        S_DUE  = 6'b001000,
        S_SEL  = 6'b010000,
        S_EMIT = 6'b100000
    } t_state;

endpackage

FILE: hw/rtl/tmq_ram.sv
// ----------------------------------------------------------------------------
// tmq_ram
// Single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module tmq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                 i_wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic [WIDTH-1:0]                 o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: hw/rtl/multi_timer_deadline_queue_core.sv
// ----------------------------------------------------------------------------
// multi_timer_deadline_queue_core
// Pool of timer slots on a microsecond time base with deadline-ordered expiry.
// ----------------------------------------------------------------------------
// Input channel (i_valid/o_ready) carries one command item: create, start,
// stop, set event, get event or tick. Output channel (o_valid/i_ready)
// carries result items; last marks the final result of an input item.
// Per-slot period, mode, event and deadline live in one RAM; used and
// running flags sit in flip-flops. One item is worked on at a time.
// A command result is registered in S_CMD after the item is accepted
// (RAM read, then modify/write), once the result register is free.
// A tick passes through S_TBND, then an S_DUE RAM scan marks due slots,
// then per expiry an S_SEL RAM scan finds the earliest deadline and an
// S_EMIT step emits it; a tick with nothing due gives no result. Ties go
// to the lower slot.
// Reset clears time, all slot flags and both registers to 1000; no
// clearing pass is needed. A stalled receiver holds the result register
// and the core waits before producing the next result.
// ----------------------------------------------------------------------------
module multi_timer_deadline_queue_core #(
    parameter int EVENT_BITS = 16,
    parameter int TIME_BITS  = 48
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic                  i_cfg_idx,
    input  logic [23:0]           i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [2:0]            i_kind,
    input  logic [4:0]            i_timer_id,
    input  logic [31:0]           i_period_us,
    input  logic                  i_periodic,
    input  logic [EVENT_BITS-1:0] i_event_id,
    input  logic [15:0]           i_elapsed,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [2:0]            o_status,
    output logic                  o_is_expiry,
    output logic [4:0]            o_result_timer,
    output logic [EVENT_BITS-1:0] o_result_event,
    output logic                  o_last
);
    import tmq_pkg::*;

    localparam int IW = $clog2(NUM_TIMERS > 1 ? NUM_TIMERS : 2);
    localparam int MW = 1 + 32 + EVENT_BITS + TIME_BITS;
    localparam logic [IW:0] NT = (IW+1)'(NUM_TIMERS);

    t_state r_state;
    logic [23:0] r_min_period, r_early;
    logic [TIME_BITS-1:0] r_now, r_bound;
    logic [NUM_TIMERS-1:0] r_used, r_run, r_due;
    logic [2:0]  r_kind;
    logic [4:0]  r_id;
    logic [31:0] r_per;
    logic        r_peri;
    logic [EVENT_BITS-1:0] r_evt;
    logic [IW:0] r_idx, r_cnt;
    logic        r_chk;
    logic [IW-1:0] r_chk_idx;
    logic        r_bvld;
    logic [IW-1:0] r_bidx;
    logic [TIME_BITS-1:0] r_bdl;
    logic [EVENT_BITS-1:0] r_bev;
    logic [31:0] r_bper;
    logic        r_bpd;
    logic        r_ovld;
    logic [2:0]  r_ostat;
    logic        r_oexp, r_olast;
    logic [4:0]  r_otimer;
    logic [EVENT_BITS-1:0] r_oev;

    logic          we;
    logic [IW-1:0] waddr, raddr;
    logic [MW-1:0] wdata, rdata;
    logic          m_pd;
    logic [31:0]   m_per;
    logic [EVENT_BITS-1:0] m_ev;
    logic [TIME_BITS-1:0]  m_dl;
    logic          out_free, acc, id_ok;
    logic [IW-1:0] cid, free_idx;
    logic          free_any;
    logic [31:0]   per_cl;
    logic [TIME_BITS:0] bsum;

    tmq_ram #(.WIDTH(MW), .DEPTH(NUM_TIMERS)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(wdata),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    assign {m_pd, m_per, m_ev, m_dl} = rdata;
    assign o_ready  = (r_state == S_IDLE);
    assign acc      = i_valid && o_ready;
    assign out_free = !r_ovld || i_ready;
    assign cid      = r_id[IW-1:0];
    assign id_ok    = {27'd0, r_id} < NUM_TIMERS;
    assign per_cl   = (r_per < {8'd0, r_min_period}) ? {8'd0, r_min_period} : r_per;
    assign bsum     = {1'b0, r_now} + {{(TIME_BITS-23){1'b0}}, r_early};

    always_comb begin
        free_any = 1'b0;
        free_idx = '0;
        for (int k = NUM_TIMERS - 1; k >= 0; k--) begin
            if (!r_used[k]) begin
                free_any = 1'b1;
                free_idx = IW'(k);
            end
        end
    end

    always_comb begin
        unique case (r_state)
            S_IDLE:         raddr = i_timer_id[IW-1:0];
            S_CMD:          raddr = cid;
            S_DUE, S_SEL:   raddr = r_idx[IW-1:0];
            default:        raddr = r_bidx;
        endcase
    end

    always_comb begin
        we    = 1'b0;
        waddr = cid;
        wdata = rdata;
        if (r_state == S_CMD && out_free) begin
            if (r_kind == K_CREATE) begin
                we    = free_any;
                waddr = free_idx;
                wdata = {r_peri, per_cl, {EVENT_BITS{1'b0}}, {TIME_BITS{1'b0}}};
            end else if (id_ok && r_used[cid]) begin
                if (r_kind == K_START && m_ev != '0 && !r_run[cid]) begin
                    we    = 1'b1;
                    wdata = {m_pd, m_per, m_ev, r_now + {{(TIME_BITS-32){1'b0}}, m_per}};
                end else if (r_kind == K_SETEV && !(m_ev != '0 && r_evt != '0)) begin
                    we    = 1'b1;
                    wdata = {m_pd, m_per, r_evt, m_dl};
                end
            end
        end else if (r_state == S_EMIT && out_free && r_bpd) begin
            we    = 1'b1;
            waddr = r_bidx;
            wdata = {r_bpd, r_bper, r_bev, r_now + {{(TIME_BITS-32){1'b0}}, r_bper}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_min_period <= RST_MIN_PERIOD;
            r_early      <= RST_EARLY_WINDOW;
            r_now        <= '0;
            r_used       <= '0;
            r_run        <= '0;
            r_due        <= '0;
            r_ovld       <= 1'b0;
            r_cnt        <= '0;
            r_idx        <= '0;
            r_chk        <= 1'b0;
            r_bvld       <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_MIN_PERIOD) begin
                    r_min_period <= i_cfg_data;
                end else begin
                    r_early <= i_cfg_data;
                end
            end
            if (r_ovld && i_ready) begin
                r_ovld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (acc) begin
                        r_kind <= i_kind;
                        r_id   <= i_timer_id;
                        r_per  <= i_period_us;
                        r_peri <= i_periodic;
                        r_evt  <= i_event_id;
                        if (i_kind == K_TICK) begin
                            r_now   <= r_now + {{(TIME_BITS-16){1'b0}}, i_elapsed};
                            r_state <= S_TBND;
                        end else if (i_kind <= K_GETEV) begin
                            r_state <= S_CMD;
                        end
                    end
                end
                S_CMD: begin
                    if (out_free) begin
                        r_ovld   <= 1'b1;
                        r_oexp   <= 1'b0;
                        r_olast  <= 1'b1;
                        r_otimer <= r_id;
                        r_oev    <= '0;
                        r_ostat  <= ST_OK;
                        r_state  <= S_IDLE;
                        if (r_kind == K_CREATE) begin
                            if (free_any) begin
                                r_used[free_idx] <= 1'b1;
                                r_run[free_idx]  <= 1'b0;
                                r_otimer         <= 5'(free_idx);
                            end else begin
                                r_ostat  <= ST_NOFREE;
                                r_otimer <= '0;
                            end
                        end else if (!id_ok || !r_used[cid]) begin
                            r_ostat <= ST_UNUSED;
                        end else begin
                            case (r_kind)
                                K_START: begin
                                    if (m_ev == '0) begin
                                        r_ostat <= ST_NOEVENT;
                                    end else if (r_run[cid]) begin
                                        r_ostat <= ST_RUNNING;
                                    end else begin
                                        r_run[cid] <= 1'b1;
                                    end
                                end
                                K_STOP: begin
                                    if (!r_run[cid]) begin
                                        r_ostat <= ST_STOPPED;
                                    end else begin
                                        r_run[cid] <= 1'b0;
                                    end
                                end
                                K_SETEV: begin
                                    if (m_ev != '0 && r_evt != '0) begin
                                        r_ostat <= ST_EVSET;
                                    end
                                end
                                default: begin
                                    r_oev <= m_ev;
                                end
                            endcase
                        end
                    end
                end
                S_TBND: begin
                    r_bound <= bsum[TIME_BITS] ? {TIME_BITS{1'b1}} : bsum[TIME_BITS-1:0];
                    r_due   <= '0;
                    r_cnt   <= '0;
                    r_idx   <= '0;
                    r_chk   <= 1'b0;
                    r_state <= S_DUE;
                end
                S_DUE, S_SEL: begin
                    r_chk     <= (r_idx < NT);
                    r_chk_idx <= r_idx[IW-1:0];
                    if (r_idx < NT) begin
                        r_idx <= r_idx + 1'b1;
                    end
                    if (r_chk) begin
                        if (r_state == S_DUE) begin
                            if (r_used[r_chk_idx] && r_run[r_chk_idx] && m_dl <= r_bound) begin
                                r_due[r_chk_idx] <= 1'b1;
                                r_cnt <= r_cnt + 1'b1;
                            end
                        end else if (r_due[r_chk_idx] && (!r_bvld || m_dl < r_bdl)) begin
                            r_bvld <= 1'b1;
                            r_bidx <= r_chk_idx;
                            r_bdl  <= m_dl;
                            r_bev  <= m_ev;
                            r_bper <= m_per;
                            r_bpd  <= m_pd;
                        end
                    end else if (r_idx == NT) begin
                        r_idx  <= '0;
                        r_bvld <= 1'b0;
                        if (r_state == S_DUE) begin
                            r_state <= (r_cnt == '0) ? S_IDLE : S_SEL;
                        end else begin
                            r_state <= S_EMIT;
                        end
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_ovld   <= 1'b1;
                        r_oexp   <= 1'b1;
                        r_ostat  <= ST_OK;
                        r_otimer <= 5'(r_bidx);
                        r_oev    <= r_bev;
                        r_olast  <= (r_cnt == (IW+1)'(1));
                        r_due[r_bidx] <= 1'b0;
                        if (!r_bpd) begin
                            r_run[r_bidx] <= 1'b0;
                        end
                        r_cnt   <= r_cnt - 1'b1;
                        r_idx   <= '0;
                        r_chk   <= 1'b0;
                        r_state <= (r_cnt == (IW+1)'(1)) ? S_IDLE : S_SEL;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid        = r_ovld;
    assign o_status       = r_ostat;
    assign o_is_expiry    = r_oexp;
    assign o_result_timer = r_otimer;
    assign o_result_event = r_oev;
    assign o_last         = r_olast;
endmodule
